// ===== rtl/bse_pkg.sv =====
// Shared constants and state encoding for the bucket sort engine.
`default_nettype none
package bse_pkg;

    localparam int DATA_W          = 16;
    localparam int DEF_MAX_ITEMS   = 64;
    localparam int DEF_VALUE_BITS  = 16;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_INS      = 6'b000010,
        S_CMP      = 6'b000100,
        S_EMIT_RD  = 6'b001000,
        S_EMIT_LD  = 6'b010000,
        S_EMIT_OUT = 6'b100000
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/bucket_sort_engine.sv =====
// Sorting engine: insertion into an ordered store, then ordered readout of the set.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata[15:0] value, s_tlast ends the set
//  m_      | out | m_tvalid/m_tready  | m_tdata[15:0] value_res, m_tlast last_res
//
// Each stored word greater than an accepted one is shifted up one slot by an S_INS read
// and an S_CMP compare-and-write; insertion ends when a word no greater is found or
// slot 0 is reached. One compare unit and the single store read port serialise this.
// Readout steps each word through S_EMIT_RD, S_EMIT_LD and S_EMIT_OUT, where any
// m_tready stall holds it. s_tready is high only between sets and insertions.
// Reset (aresetn low, synchronous) empties the set and drops a pending output.
`default_nettype none
module bucket_sort_engine #(
    parameter int MAX_ITEMS  = bse_pkg::DEF_MAX_ITEMS,
    parameter int VALUE_BITS = bse_pkg::DEF_VALUE_BITS
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [bse_pkg::DATA_W-1:0] s_tdata,   // [15:0] value
    input  wire logic                       s_tlast,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [bse_pkg::DATA_W-1:0]      m_tdata,   // [15:0] value_res
    output logic                            m_tlast
);
    import bse_pkg::*;

    localparam int SW    = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;
    localparam int AW    = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_ITEMS);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [AW-1:0]      j_reg, j_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [SW-1:0]      x_reg, x_next;
    logic               set_end_reg, set_end_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic               m_tlast_reg, m_tlast_next;

    logic [SW-1:0]      mem [MAX_ITEMS];
    logic [SW-1:0]      rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [SW-1:0]      wr_data;
    logic               s_fire;
    logic               is_final;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign is_final = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        j_next        = j_reg;
        idx_next      = idx_reg;
        x_next        = x_reg;
        set_end_next  = set_end_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        rd_addr       = idx_reg;
        wr_en         = 1'b0;
        wr_addr       = j_reg;
        wr_data       = x_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    x_next       = s_tdata[SW-1:0];
                    set_end_next = s_tlast;
                    idx_next     = '0;
                    if (count_reg < FULL) begin
                        j_next     = count_reg[AW-1:0];
                        state_next = S_INS;
                    end else if (s_tlast) begin
                        // store full: drop the word, still sort what is held
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_INS: begin
                if (j_reg == '0) begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    state_next = set_end_reg ? S_EMIT_RD : S_IDLE;
                end else begin
                    rd_addr    = j_reg - AW'(1);
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                wr_en = 1'b1;
                if (rd_data_reg > x_reg) begin
                    // shift the larger word up one slot
                    wr_data    = rd_data_reg;
                    j_next     = j_reg - AW'(1);
                    state_next = S_INS;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = set_end_reg ? S_EMIT_RD : S_IDLE;
                end
            end
            S_EMIT_RD: begin
                rd_addr    = idx_reg;
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = DATA_W'(rd_data_reg);
                m_tlast_next  = is_final;
                state_next    = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    if (m_tlast_reg) begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        j_reg       <= j_next;
        idx_reg     <= idx_next;
        x_reg       <= x_next;
        set_end_reg <= set_end_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL)
        else $error("stored word count beyond capacity");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && ((count_reg < FULL) || s_tlast)) |=> !s_tready)
        else $error("input taken again without insertion");

    a_valid_only_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (state_reg == S_EMIT_OUT))
        else $error("output valid outside readout hold");

    a_set_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (count_reg == '0) && s_tready)
        else $error("set not cleared after final word");

endmodule
`default_nettype wire
